@@ design/assert_macros.svh @@
// Assertion macros used by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CSVP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csvp assertion failed");

// Next-cycle implication, checked outside reset.
`define CSVP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csvp assertion failed");

`endif

@@ design/csvp_pkg.sv @@
// Types and constants of the CSV byte stream parser.
package csvp_pkg;

   localparam logic [7:0] CH_QUOTE      = 8'd34;
   localparam logic [7:0] CH_LF         = 8'd10;
   localparam logic [7:0] CH_CR         = 8'd13;
   localparam logic [7:0] DEFAULT_DELIM = 8'd44;

   // most tokens one byte can cause
   localparam int RUN_MAX     = 4;
   localparam int RUN_IDX_W   = $clog2(RUN_MAX);
   localparam int RUN_CNT_W   = $clog2(RUN_MAX + 1);
   localparam int QUEUE_DEPTH = 4;

   localparam int REG_DELIMITER = 0;

   typedef enum logic [1:0] {
      TK_BYTE  = 2'd0,
      TK_FIELD = 2'd1,
      TK_ROW   = 2'd2,
      TK_DONE  = 2'd3
   } tok_kind_type;

   // all tokens caused by one input byte
   typedef struct packed {
      logic [RUN_CNT_W-1:0]          count;
      logic [RUN_MAX-1:0][1:0]       kind;
      logic [RUN_MAX-1:0][7:0]       data;
   } tok_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

@@ design/csvp_front.sv @@
// Front end: classifies each byte, tracks parse state, builds its token run.
module csvp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             delimiter,
   input  logic                   accept,
   input  logic [7:0]             in_byte,
   input  logic                   end_of_data,
   output logic                   push,
   output csvp_pkg::tok_entry_type entry
);
   import csvp_pkg::*;

   logic quoted_ff, quoted_in;
   logic quote_held_ff, quote_held_in;
   logic skip_lf_ff, skip_lf_in;
   logic field_ne_ff, field_ne_in;
   logic row_fields_ff, row_fields_in;
   logic row_held_ff, row_held_in;

   logic         do_plain;
   logic         do_emit;
   logic         do_row_end;
   tok_kind_type emit_kind;
   logic [7:0]   emit_byte;
   tok_entry_type ent;

   always_comb begin
      quoted_in     = quoted_ff;
      quote_held_in = quote_held_ff;
      skip_lf_in    = 1'b0;
      field_ne_in   = field_ne_ff;
      row_fields_in = row_fields_ff;
      row_held_in   = row_held_ff;
      do_plain      = 1'b0;
      do_emit       = 1'b0;
      do_row_end    = 1'b0;
      emit_kind     = TK_BYTE;
      emit_byte     = in_byte;
      ent           = '0;

      if (quoted_ff) begin
         if (quote_held_ff) begin
            quote_held_in = 1'b0;
            if (in_byte == CH_QUOTE) begin
               do_emit     = 1'b1;
               field_ne_in = 1'b1;
            end else begin
               quoted_in = 1'b0;
               do_plain  = 1'b1;
            end
         end else if (in_byte == CH_QUOTE) begin
            quote_held_in = 1'b1;
         end else begin
            do_emit     = 1'b1;
            field_ne_in = 1'b1;
         end
      end else if (!(skip_lf_ff && in_byte == CH_LF)) begin
         do_plain = 1'b1;
      end

      // unquoted meaning; quote wins over delimiter, delimiter over line breaks
      if (do_plain) begin
         if (in_byte == CH_QUOTE) begin
            quoted_in = 1'b1;
         end else if (in_byte == delimiter) begin
            do_emit       = 1'b1;
            emit_kind     = TK_FIELD;
            emit_byte     = 8'd0;
            row_fields_in = 1'b1;
            field_ne_in   = 1'b0;
         end else if (in_byte == CH_LF || in_byte == CH_CR) begin
            do_row_end = 1'b1;
            skip_lf_in = (in_byte == CH_CR);
         end else begin
            do_emit     = 1'b1;
            field_ne_in = 1'b1;
         end
      end

      if (do_emit) begin
         if (row_held_in) begin
            ent.kind[ent.count[RUN_IDX_W-1:0]] = TK_ROW;
            ent.count = ent.count + RUN_CNT_W'(1);
            row_held_in = 1'b0;
         end
         ent.kind[ent.count[RUN_IDX_W-1:0]] = emit_kind;
         ent.data[ent.count[RUN_IDX_W-1:0]] = emit_byte;
         ent.count = ent.count + RUN_CNT_W'(1);
      end

      if (do_row_end) begin
         // a row with one empty field waits until more output shows up
         if (!row_fields_in && !field_ne_in) begin
            if (row_held_in) begin
               ent.kind[ent.count[RUN_IDX_W-1:0]] = TK_ROW;
               ent.count = ent.count + RUN_CNT_W'(1);
            end
            row_held_in = 1'b1;
         end else begin
            if (row_held_in) begin
               ent.kind[ent.count[RUN_IDX_W-1:0]] = TK_ROW;
               ent.count = ent.count + RUN_CNT_W'(1);
               row_held_in = 1'b0;
            end
            ent.kind[ent.count[RUN_IDX_W-1:0]] = TK_ROW;
            ent.count = ent.count + RUN_CNT_W'(1);
         end
         row_fields_in = 1'b0;
         field_ne_in   = 1'b0;
      end

      if (end_of_data) begin
         if (quote_held_in) begin
            quote_held_in = 1'b0;
            quoted_in     = 1'b0;
         end
         if (field_ne_in || row_fields_in || quoted_in) begin
            if (!row_fields_in && !field_ne_in) begin
               if (row_held_in) begin
                  ent.kind[ent.count[RUN_IDX_W-1:0]] = TK_ROW;
                  ent.count = ent.count + RUN_CNT_W'(1);
               end
            end else begin
               if (row_held_in) begin
                  ent.kind[ent.count[RUN_IDX_W-1:0]] = TK_ROW;
                  ent.count = ent.count + RUN_CNT_W'(1);
               end
               ent.kind[ent.count[RUN_IDX_W-1:0]] = TK_ROW;
               ent.count = ent.count + RUN_CNT_W'(1);
            end
         end
         ent.kind[ent.count[RUN_IDX_W-1:0]] = TK_DONE;
         ent.count     = ent.count + RUN_CNT_W'(1);
         quoted_in     = 1'b0;
         quote_held_in = 1'b0;
         skip_lf_in    = 1'b0;
         field_ne_in   = 1'b0;
         row_fields_in = 1'b0;
         row_held_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quoted_ff     <= 1'b0;
         quote_held_ff <= 1'b0;
         skip_lf_ff    <= 1'b0;
         field_ne_ff   <= 1'b0;
         row_fields_ff <= 1'b0;
         row_held_ff   <= 1'b0;
      end else if (accept) begin
         quoted_ff     <= quoted_in;
         quote_held_ff <= quote_held_in;
         skip_lf_ff    <= skip_lf_in;
         field_ne_ff   <= field_ne_in;
         row_fields_ff <= row_fields_in;
         row_held_ff   <= row_held_in;
      end
   end

   assign push  = accept && (ent.count != '0);
   assign entry = ent;

endmodule

@@ design/csvp_queue.sv @@
// Short queue of token runs between the front and back ends.
module csvp_queue #(
   parameter int DEPTH = csvp_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  csvp_pkg::tok_entry_type   push_entry,
   input  logic                      pop,
   output csvp_pkg::tok_entry_type   head,
   output csvp_pkg::queue_status_type status
);
   import csvp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tok_entry_type slot_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic do_push;
   logic do_pop;

   assign do_push = push && (count_ff != CNT_W'(DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));

endmodule

@@ design/csvp_back.sv @@
// Back end: walks each token run and drives the registered result channel.
module csvp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  csvp_pkg::tok_entry_type    head,
   input  csvp_pkg::queue_status_type status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_token_kind,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_last_of_run
);
   import csvp_pkg::*;

   logic [RUN_IDX_W-1:0] idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   logic [1:0]           kind_ff;
   logic [7:0]           data_ff;
   logic                 last_ff;

   logic load;
   logic at_last;

   assign load    = !valid_ff || !rsp_stall;
   assign at_last = ((RUN_CNT_W'(idx_ff) + RUN_CNT_W'(1)) == head.count);
   assign pop     = load && !status.empty && at_last;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = !status.empty;
         if (!status.empty) begin
            idx_in = at_last ? '0 : idx_ff + RUN_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && !status.empty) begin
         kind_ff <= head.kind[idx_ff];
         data_ff <= head.data[idx_ff];
         last_ff <= at_last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_token_kind  = kind_ff;
   assign rsp_out_byte    = data_ff;
   assign rsp_last_of_run = last_ff;

endmodule

@@ design/csv_byte_stream_parser_core.sv @@
// CSV byte stream parser top level: CSR, front end, run queue, back end.
// The first token of a byte is written into a run queue slot, then into the result register.
// Throughput: one byte per cycle unless the run queue is full; the tokens of a byte leave
// one at a time through the single result register; the run queue absorbs QUEUE_DEPTH runs.
// Reset (synchronous, active high) clears parse state and queue, delimiter to comma.
`include "assert_macros.svh"

module csv_byte_stream_parser_core #(
   parameter int QUEUE_DEPTH = csvp_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_data,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_token_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import csvp_pkg::*;

   logic [7:0]        delim_ff;
   logic              req_accept;
   logic              push;
   logic              pop;
   tok_entry_type     push_entry;
   tok_entry_type     head;
   queue_status_type  q_status;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'(REG_DELIMITER)) ? {24'd0, delim_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= DEFAULT_DELIM;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[2] == 1'(REG_DELIMITER)) begin
         delim_ff <= csr_pwdata[7:0];
      end
   end

   assign req_stall  = q_status.full;
   assign req_accept = req_valid && !req_stall;

   csvp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .delimiter   (delim_ff),
      .accept      (req_accept),
      .in_byte     (req_in_byte),
      .end_of_data (req_end_of_data),
      .push        (push),
      .entry       (push_entry)
   );

   csvp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   csvp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .status          (q_status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // the done token always closes its run
   `CSVP_ASSERT_IMPL(a_done_is_last, clock, reset,
      rsp_valid && rsp_token_kind == TK_DONE, rsp_last_of_run)
   // only content bytes carry data
   `CSVP_ASSERT_IMPL(a_byte_only_content, clock, reset,
      rsp_valid && rsp_token_kind != TK_BYTE, rsp_out_byte == 8'd0)
   // a run is queued whole, so its tokens leave without gaps
   `CSVP_ASSERT_NEXT(a_run_no_gap, clock, reset,
      rsp_valid && !rsp_stall && !rsp_last_of_run, rsp_valid)

endmodule
